// ----- design/bafs_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// bafs_pkg
// Shared types, constants and helpers of the bracket aware field splitter.
// ============================================================================
package bafs_pkg;

    localparam int STACK_DEPTH   = 32;
    localparam int POSITION_BITS = 16;
    localparam int LEVEL_BITS    = $clog2(STACK_DEPTH + 1);
    localparam int INDEX_BITS    = $clog2(STACK_DEPTH);

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    localparam logic [7:0] DELIM_RESET  = 8'd44;
    localparam logic [7:0] CHAR_LROUND  = 8'h28;
    localparam logic [7:0] CHAR_RROUND  = 8'h29;
    localparam logic [7:0] CHAR_LCURLY  = 8'h7b;
    localparam logic [7:0] CHAR_RCURLY  = 8'h7d;
    localparam logic [7:0] CHAR_LSQUARE = 8'h5b;
    localparam logic [7:0] CHAR_RSQUARE = 8'h5d;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_ROUND  = 2'd1,
        KIND_CURLY  = 2'd2,
        KIND_SQUARE = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] character;
        logic       end_of_string;
    } in_item_t;

    typedef struct packed {
        logic [15:0] token_offset;
        logic [15:0] token_length;
        logic        token_is_final;
        logic        overflow;
    } out_item_t;

    function automatic kind_t opener_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            CHAR_LROUND:  k = KIND_ROUND;
            CHAR_LCURLY:  k = KIND_CURLY;
            CHAR_LSQUARE: k = KIND_SQUARE;
            default:      k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic kind_t closer_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            CHAR_RROUND:  k = KIND_ROUND;
            CHAR_RCURLY:  k = KIND_CURLY;
            CHAR_RSQUARE: k = KIND_SQUARE;
            default:      k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

// ----- design/bafs_if.sv -----
`timescale 1ns / 1ps
// ============================================================================
// bafs_in_if / bafs_out_if
// Valid/ready request channels for characters in and tokens out.
// ============================================================================
interface bafs_in_if;
    logic               valid;
    logic               ready;
    bafs_pkg::in_item_t data;

    modport source  (output valid, output data, input ready);
    modport sink    (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

interface bafs_out_if;
    logic                valid;
    logic                ready;
    bafs_pkg::out_item_t data;

    modport source  (output valid, output data, input ready);
    modport sink    (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

// ----- design/bracket_aware_field_splitter.sv -----
`timescale 1ns / 1ps
// ============================================================================
// bracket_aware_field_splitter
// Splits a byte string at a delimiter that stands outside any open bracket.
// ============================================================================
// One character request is taken per cycle while ready. Each character is
// decoded combinationally against the bracket stack top, the level and the
// positions, and any token goes into a one-entry output register. The input
// is ready whenever that register is empty or is being drained in the same
// cycle, so with a ready sink the block runs at one byte per clock and a
// token leaves in the cycle after the byte that ends it. The delimiter
// register is written with delimiter_we and resets to a comma. The stack
// holds STACK_DEPTH brackets; nesting deeper or strings longer than the
// position range set a sticky overflow flag that only reset clears.
module bracket_aware_field_splitter (
    input  logic                clk,
    input  logic                rst_n,
    bafs_in_if.sink             in_ch,
    bafs_out_if.source          out_ch,
    input  logic                delimiter_we,
    input  logic [7:0]          delimiter_data
);
    import bafs_pkg::*;

    logic [7:0]               delim_reg;
    kind_t                    stack_reg [STACK_DEPTH];
    logic [LEVEL_BITS-1:0]    level_reg, level_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic                     ovf_reg, ovf_next;
    logic                     out_valid_reg;
    out_item_t                out_data_reg;

    logic                     accept;
    logic                     sat, last;
    logic [POSITION_BITS-1:0] next_pos, tok_len;
    kind_t                    ok, ck, top;
    logic                     is_open, full, push, pop, split, final_emit, emit;
    logic [INDEX_BITS-1:0]    top_index, push_index;
    logic [LEVEL_BITS-1:0]    level_dec;

    assign in_ch.ready  = !out_valid_reg || out_ch.ready;
    assign accept       = in_ch.valid && in_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    always_comb
    begin
        last       = in_ch.data.end_of_string;
        sat        = (pos_reg == POS_MAX);
        next_pos   = sat ? pos_reg : pos_reg + 1'b1;
        ok         = opener_kind(in_ch.data.character);
        ck         = closer_kind(in_ch.data.character);
        level_dec  = level_reg - 1'b1;
        top_index  = level_dec[INDEX_BITS-1:0];
        push_index = level_reg[INDEX_BITS-1:0];
        top        = stack_reg[top_index];
        is_open    = (ok != KIND_NONE);
        full       = (level_reg == LEVEL_BITS'(STACK_DEPTH));
        push       = is_open && !full;
        pop        = !is_open && (ck != KIND_NONE) && (level_reg != '0) && (top == ck);
        split      = !is_open && !pop && (in_ch.data.character == delim_reg)
                     && (level_reg == '0);
        final_emit = !split && last && (next_pos > start_reg);
        emit       = split || final_emit;

        if (split)
        begin
            tok_len = (pos_reg >= start_reg) ? pos_reg - start_reg : '0;
        end
        else
        begin
            tok_len = next_pos - start_reg;
        end

        ovf_next = ovf_reg || sat || (is_open && full);

        if (last)
        begin
            level_next = '0;
            pos_next   = '0;
            start_next = '0;
        end
        else
        begin
            pos_next   = next_pos;
            start_next = split ? next_pos : start_reg;
            if (push)
            begin
                level_next = level_reg + 1'b1;
            end
            else if (pop)
            begin
                level_next = level_dec;
            end
            else
            begin
                level_next = level_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg     <= DELIM_RESET;
            level_reg     <= '0;
            pos_reg       <= '0;
            start_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (delimiter_we)
            begin
                delim_reg <= delimiter_data;
            end
            if (accept)
            begin
                level_reg     <= level_next;
                pos_reg       <= pos_next;
                start_reg     <= start_next;
                ovf_reg       <= ovf_next;
                out_valid_reg <= emit;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // stack entries and token payload carry no reset
    always_ff @(posedge clk)
    begin
        if (accept && push)
        begin
            stack_reg[push_index] <= ok;
        end
        if (accept && emit)
        begin
            out_data_reg.token_offset   <= 16'(start_reg);
            out_data_reg.token_length   <= 16'(tok_len);
            out_data_reg.token_is_final <= last;
            out_data_reg.overflow       <= ovf_next;
        end
    end

endmodule

// ----- design/bafs_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// bafs_checker
// Port-level assertions for the bracket aware field splitter.
// ============================================================================
module bafs_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                out_valid,
    input  logic                out_ready,
    input  bafs_pkg::out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("token request dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("token payload changed while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input not ready with empty output");

    a_out_from_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("token appeared without a character request");

    a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.overflow |=> !out_valid || out_data.overflow)
        else $error("overflow flag cleared");

endmodule

bind bracket_aware_field_splitter bafs_checker u_bafs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);
